[design/i2c_mbe_pkg.sv]
// Shared types and constants for the I2C master byte engine.
package i2c_mbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASE_W       = 5;
  // Bit loop bounds: a write loops while below its end (three ticks per bit),
  // a read loops up to and including its end (two ticks per bit)
  localparam logic [PHASE_W-1:0] WR_BITS_END = PHASE_W'(3 * BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] RD_BITS_END = PHASE_W'(2 * BITS_PER_BYTE);

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SUB_DATA = 2'd0,
    SUB_RISE = 2'd1,
    SUB_FALL = 2'd2
  } sub_e;

  typedef struct packed {
    logic [2:0]               command;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     send_ack;
    logic                     sda_in;
  } in_item_t;

  typedef struct packed {
    logic                     scl_out;
    logic                     sda_out;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     ack_level;
  } out_item_t;

  typedef struct packed {
    op_e                      op;
    logic [PHASE_W-1:0]       phase;
    sub_e                     sub;
    logic [BITS_PER_BYTE-1:0] shift_out;
    logic [BITS_PER_BYTE-1:0] shift_in;
    logic                     ack_req;
    logic                     ack_seen;
    logic                     scl;
    logic                     sda;
  } eng_state_t;

endpackage

[design/i2c_mbe_step.sv]
// Per-tick pin action logic: next engine state and result item.
module i2c_mbe_step import i2c_mbe_pkg::*; (
  input  eng_state_t cur_i,
  input  in_item_t   item_i,
  output eng_state_t nxt_o,
  output out_item_t  res_o
);

  logic               start;
  logic               last;
  logic               active;
  op_e                op;
  logic [PHASE_W-1:0] p;
  sub_e               r;
  eng_state_t         nxt;

  // Command decode: only taken while idle, unused codes are ignored
  always_comb begin
    start = (cur_i.op == OP_IDLE) &&
            (item_i.command >= OP_START) && (item_i.command <= OP_READ);
    op    = start ? op_e'(item_i.command) : cur_i.op;
    p     = start ? '0 : cur_i.phase;
    r     = start ? SUB_DATA : cur_i.sub;
  end

  // Pin action for the current phase
  always_comb begin
    nxt          = cur_i;
    nxt.op       = op;
    last         = 1'b0;
    active       = (op != OP_IDLE);
    if (start && op == OP_WRITE) nxt.shift_out = item_i.tx_byte;
    if (start && op == OP_READ)  nxt.ack_req   = item_i.send_ack;

    case (op)
      OP_START: begin
        case (p)
          PHASE_W'(0): nxt.sda = 1'b1;
          PHASE_W'(1): nxt.scl = 1'b1;
          PHASE_W'(2): nxt.sda = 1'b0;
          default:     nxt.scl = 1'b0;
        endcase
        last = (p >= PHASE_W'(3));
      end
      OP_STOP: begin
        case (p)
          PHASE_W'(0): nxt.sda = 1'b0;
          PHASE_W'(1): nxt.scl = 1'b1;
          default:     nxt.sda = 1'b1;
        endcase
        last = (p >= PHASE_W'(2));
      end
      OP_WRITE: begin
        if (p < WR_BITS_END) begin
          case (r)
            SUB_DATA: nxt.sda = nxt.shift_out[BITS_PER_BYTE-1];
            SUB_RISE: begin
              nxt.scl       = 1'b1;
              nxt.shift_out = {nxt.shift_out[BITS_PER_BYTE-2:0], 1'b0};
            end
            default:  nxt.scl = 1'b0;
          endcase
        end else if (p == WR_BITS_END) begin
          nxt.sda = 1'b1;
        end else if (p == WR_BITS_END + PHASE_W'(1)) begin
          nxt.scl      = 1'b1;
          nxt.ack_seen = item_i.sda_in;
        end else begin
          nxt.scl = 1'b0;
        end
        last = (p >= WR_BITS_END + PHASE_W'(2));
      end
      OP_READ: begin
        if (p == '0) begin
          nxt.sda      = 1'b1;
          nxt.shift_in = '0;
        end else if (p <= RD_BITS_END) begin
          // odd phases raise SCL and sample, even phases lower it
          if (p[0]) begin
            nxt.scl      = 1'b1;
            nxt.shift_in = {cur_i.shift_in[BITS_PER_BYTE-2:0], item_i.sda_in};
          end else begin
            nxt.scl = 1'b0;
          end
        end else if (p == RD_BITS_END + PHASE_W'(1)) begin
          nxt.sda = ~nxt.ack_req;
        end else if (p == RD_BITS_END + PHASE_W'(2)) begin
          nxt.scl = 1'b1;
        end else if (p == RD_BITS_END + PHASE_W'(3)) begin
          nxt.scl = 1'b0;
        end else begin
          nxt.sda = 1'b1;
        end
        last = (p >= RD_BITS_END + PHASE_W'(4));
      end
      default: begin
        last = 1'b0;
      end
    endcase

    // Sequence bookkeeping
    if (active && last) begin
      nxt.op    = OP_IDLE;
      nxt.phase = '0;
      nxt.sub   = SUB_DATA;
    end else if (active) begin
      nxt.phase = p + PHASE_W'(1);
      case (r)
        SUB_DATA: nxt.sub = SUB_RISE;
        SUB_RISE: nxt.sub = SUB_FALL;
        default:  nxt.sub = SUB_DATA;
      endcase
    end
  end

  assign nxt_o = nxt;

  // Result item reflects the levels after this tick
  assign res_o = '{
    scl_out:   nxt.scl,
    sda_out:   nxt.sda,
    busy_res:  (nxt.op != OP_IDLE),
    done_res:  active && last,
    rx_byte:   nxt.shift_in,
    ack_level: nxt.ack_seen
  };

endmodule

[design/i2c_mbe_skid.sv]
// Output register with a skid stage for the result channel.
module i2c_mbe_skid import i2c_mbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  out_item_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;
  logic      push, pop;

  assign in_stall_o = skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;

  // Next-state for the two slots
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_data_d  = in_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = in_data_i;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload flops
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/i2c_mbe_state.sv]
// Engine state register, advanced once per accepted tick.
module i2c_mbe_state import i2c_mbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  eng_state_t nxt_i,
  output eng_state_t cur_o
);

  eng_state_t st_q, st_d;

  assign st_d = adv_i ? nxt_i : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{
        op:        OP_IDLE,
        phase:     '0,
        sub:       SUB_DATA,
        shift_out: '0,
        shift_in:  '0,
        ack_req:   1'b0,
        ack_seen:  1'b1,
        scl:       1'b1,
        sda:       1'b1
      };
    end else begin
      st_q <= st_d;
    end
  end

  assign cur_o = st_q;

endmodule

[design/i2c_master_byte_engine_unit.sv]
// I2C master byte engine: one pin action per tick, with a registered result per tick.
// Throughput: one tick per cycle while the skid slot is empty; the state update is a
// single pass of the action logic. A two-deep output buffer (output slot, skid slot)
// takes one more result while the result side stalls, then stalls the input.
// Reset: engine idle, SCL and SDA released high, ack level high, no results pending.
module i2c_master_byte_engine_unit import i2c_mbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  eng_state_t cur, nxt;
  out_item_t  res;
  logic       accept;

  assign accept = in_valid_i && !in_stall_o;

  i2c_mbe_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .nxt_i  (nxt),
    .cur_o  (cur)
  );

  i2c_mbe_step u_step (
    .cur_i  (cur),
    .item_i (in_data_i),
    .nxt_o  (nxt),
    .res_o  (res)
  );

  i2c_mbe_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[test/i2c_master_byte_engine_unit_test.sv]
// Self-checking testbench for the I2C master byte engine unit.
`timescale 1ns / 100ps

module i2c_master_byte_engine_unit_test;
  import i2c_mbe_pkg::*;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int RANDOM_TICKS  = 1600;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 50;
  // Command codes outside the operation set, treated as no command
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  // How the bus device drives SDA back during an operation
  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_e;

  // Pin-level predictor plus the queue of expected tick results
  class pin_scoreboard;
    op_e                      op_q;
    logic [PHASE_W-1:0]       phase_q;
    logic [BITS_PER_BYTE-1:0] tx_shift;
    logic [BITS_PER_BYTE-1:0] rx_shift;
    logic                     ack_req;
    logic                     ack_seen;
    logic                     scl_lvl;
    logic                     sda_lvl;
    out_item_t                expected_pins[$];
    int                       mismatches;
    int                       results_checked;
    int                       ops_done[5];
    int                       acks_seen;
    int                       nacks_seen;

    function new();
      op_q            = OP_IDLE;
      phase_q         = '0;
      tx_shift        = '0;
      rx_shift        = '0;
      ack_req         = 1'b0;
      ack_seen        = 1'b1;
      scl_lvl         = 1'b1;
      sda_lvl         = 1'b1;
      mismatches      = 0;
      results_checked = 0;
      acks_seen       = 0;
      nacks_seen      = 0;
      foreach (ops_done[k]) ops_done[k] = 0;
    endfunction

    function bit is_idle();
      return op_q == OP_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // One pin action at the current phase; returns 1 on the operation's last action
    function bit pin_action(logic sda_in);
      int p;
      int b;
      p = int'(phase_q);
      b = BITS_PER_BYTE;
      case (op_q)
        OP_START: begin
          if (p == 0) sda_lvl = 1'b1;
          else if (p == 1) scl_lvl = 1'b1;
          else if (p == 2) sda_lvl = 1'b0;
          else scl_lvl = 1'b0;
          return p >= 3;
        end
        OP_STOP: begin
          if (p == 0) sda_lvl = 1'b0;
          else if (p == 1) scl_lvl = 1'b1;
          else sda_lvl = 1'b1;
          return p >= 2;
        end
        OP_WRITE: begin
          // Data bits: drive MSB, raise SCL, lower SCL
          if (p < 3 * b) begin
            case (sub_e'(2'(p % 3)))
              SUB_DATA: sda_lvl = tx_shift[BITS_PER_BYTE-1];
              SUB_RISE: begin
                scl_lvl  = 1'b1;
                tx_shift = tx_shift << 1;
              end
              default: scl_lvl = 1'b0;
            endcase
            return 1'b0;
          end
          // Acknowledge clock, sampled while SCL is high
          if (p == 3 * b) sda_lvl = 1'b1;
          else if (p == 3 * b + 1) begin
            scl_lvl  = 1'b1;
            ack_seen = sda_in;
          end else scl_lvl = 1'b0;
          return p >= 3 * b + 2;
        end
        OP_READ: begin
          if (p == 0) begin
            sda_lvl  = 1'b1;
            rx_shift = '0;
            return 1'b0;
          end
          // Data bits: shift in on the rising tick, then lower SCL
          if (p <= 2 * b) begin
            if (p % 2 == 1) begin
              scl_lvl  = 1'b1;
              rx_shift = {rx_shift[BITS_PER_BYTE-2:0], sda_in};
            end else scl_lvl = 1'b0;
            return 1'b0;
          end
          // ACK or NACK clock, then release SDA
          if (p == 2 * b + 1) sda_lvl = !ack_req;
          else if (p == 2 * b + 2) scl_lvl = 1'b1;
          else if (p == 2 * b + 3) scl_lvl = 1'b0;
          else sda_lvl = 1'b1;
          return p >= 2 * b + 4;
        end
        default: return 1'b1;
      endcase
    endfunction

    // Expected result of one tick; commands count only while idle
    function out_item_t predict_pins(in_item_t it);
      out_item_t res;
      logic      last;
      last = 1'b0;
      if (op_q == OP_IDLE && it.command >= OP_START && it.command <= OP_READ) begin
        op_q    = op_e'(it.command);
        phase_q = '0;
        if (op_q == OP_WRITE) tx_shift = it.tx_byte;
        if (op_q == OP_READ) ack_req = it.send_ack;
      end
      if (op_q != OP_IDLE) begin
        last = pin_action(it.sda_in);
        if (last) begin
          if (op_q == OP_WRITE) begin
            if (ack_seen) nacks_seen++;
            else acks_seen++;
          end
          ops_done[int'(op_q)]++;
          op_q    = OP_IDLE;
          phase_q = '0;
        end else begin
          phase_q = phase_q + PHASE_W'(1);
        end
      end
      res.scl_out   = scl_lvl;
      res.sda_out   = sda_lvl;
      res.busy_res  = (op_q != OP_IDLE);
      res.done_res  = last;
      res.rx_byte   = rx_shift;
      res.ack_level = ack_seen;
      return res;
    endfunction

    function void note_tick(in_item_t it);
      expected_pins.push_back(predict_pins(it));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", results_checked, field, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        report($sformatf("result %0h arrived with nothing expected", got));
      end else begin
        want = expected_pins.pop_front();
        check_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
        check_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(got.done_res), 8'(want.done_res));
        check_field("rx_byte", got.rx_byte, want.rx_byte);
        check_field("ack_level", 8'(got.ack_level), 8'(want.ack_level));
        results_checked++;
      end
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  pin_scoreboard pins_sb = new();

  int cycle_count  = 0;
  int ticks_sent   = 0;
  int hold_req_cnt = 0;
  int hold_seen    = 0;
  int stall_left   = 0;
  int calm_left    = 0;
  bit steady_send  = 1'b0;

  i2c_master_byte_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("i2c_master_byte_engine_unit_test failed");
    $finish;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic sda_level(sda_mode_e m);
    if (m == SDA_LOW) return 1'b0;
    if (m == SDA_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  // Result side: check each transfer, then pick the next stall level
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) pins_sb.check_result(out_data_o);
    if (hold_req_cnt != hold_seen) begin
      hold_seen  = hold_req_cnt;
      stall_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(20, 80);
    end else begin
      stall_left = pick_gap();
    end
    out_stall_i <= (stall_left > 0);
  end

  // Offer one tick and wait for its transfer
  task automatic send_tick(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pins_sb.note_tick(it);
    ticks_sent++;
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pins_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic request_hold();
    hold_req_cnt <= hold_req_cnt + 1;
  endtask

  // Issue a command tick, then tick until the engine is idle again;
  // noisy ticks carry stray commands that a busy engine must ignore
  task automatic run_op(logic [2:0] cmd, logic [7:0] tx, logic ack, sda_mode_e m, bit noisy);
    in_item_t it;
    it.command  = cmd;
    it.tx_byte  = tx;
    it.send_ack = ack;
    it.sda_in   = sda_level(m);
    send_tick(it);
    if (!steady_send) pause_sender(pick_gap());
    while (!pins_sb.is_idle()) begin
      it.command = OP_IDLE;
      if (noisy && $urandom_range(0, 3) == 0) it.command = 3'($urandom_range(0, 7));
      it.tx_byte  = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in   = sda_level(m);
      send_tick(it);
      if (!steady_send) pause_sender(pick_gap());
    end
  endtask

  task automatic random_byte_op(bit noisy);
    if ($urandom_range(0, 1))
      run_op(OP_WRITE, 8'($urandom), 1'($urandom), sda_mode_e'($urandom_range(0, 2)), noisy);
    else
      run_op(OP_READ, 8'($urandom), 1'($urandom), sda_mode_e'($urandom_range(0, 2)), noisy);
  endtask

  initial begin
    int random_goal;
    int pick;
    bit noisy;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick and unused codes, then every operation at the byte extremes
    run_op(OP_IDLE, 8'h00, 1'b0, SDA_RAND, 1'b0);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
      run_op(3'(c), 8'hFF, 1'b1, SDA_RAND, 1'b0);
    run_op(OP_START, 8'hA5, 1'b0, SDA_RAND, 1'b1);
    run_op(OP_WRITE, 8'hFF, 1'b0, SDA_HIGH, 1'b1);
    run_op(OP_WRITE, 8'h00, 1'b1, SDA_LOW, 1'b1);
    run_op(OP_READ, 8'h00, 1'b1, SDA_HIGH, 1'b1);
    run_op(OP_READ, 8'hFF, 1'b0, SDA_LOW, 1'b1);
    run_op(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
    run_op(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
    drain_results();

    // Long result hold-off while ticks keep coming back to back
    request_hold();
    steady_send = 1'b1;
    run_op(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    random_byte_op(1'b0);
    random_byte_op(1'b0);
    steady_send = 1'b0;
    drain_results();

    // Random: mostly well-formed transfers, some stray or out-of-order commands
    random_goal = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < random_goal) begin
      steady_send = ($urandom_range(0, 4) == 0);
      noisy       = ($urandom_range(0, 2) == 0);
      pick        = $urandom_range(0, 99);
      if (pick < 3) begin
        request_hold();
        steady_send = 1'b1;
      end else if (pick < 6) begin
        drain_results();
      end
      if (pick < 85) begin
        run_op(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
        repeat ($urandom_range(1, 3)) random_byte_op(noisy);
        if ($urandom_range(0, 5) != 0) run_op(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
      end else begin
        run_op(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SDA_RAND, 1'b1);
      end
    end
    steady_send = 1'b0;

    // Wind down
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pins_sb.pending() != 0)
      pins_sb.report($sformatf("%0d results never arrived", pins_sb.pending()));

    $display("Ran %0d ticks over %0d cycles, %0d results checked, %0d mismatches.",
             ticks_sent, cycle_count, pins_sb.results_checked, pins_sb.mismatches);
    $display("Completed %0d start, %0d stop, %0d write (%0d acked, %0d not), %0d read.",
             pins_sb.ops_done[int'(OP_START)], pins_sb.ops_done[int'(OP_STOP)],
             pins_sb.ops_done[int'(OP_WRITE)], pins_sb.acks_seen, pins_sb.nacks_seen,
             pins_sb.ops_done[int'(OP_READ)]);
    if (pins_sb.mismatches == 0) begin
      $display("i2c_master_byte_engine_unit_test passed");
    end else begin
      $display("i2c_master_byte_engine_unit_test failed");
    end
    $finish;
  end

endmodule
